// ----- hw/rtl/scd_pkg.sv -----
// scd_pkg: shared types, codes and constants of the sync command deframer
// no dependencies; imported by the parser and the top level
`default_nettype none

package scd_pkg;

   // ascii sync word "newtntp ", first byte received in the top byte
   localparam logic [63:0] SYNC_WORD = 64'h6E6577746E747020;

   // bytes in the sync window and in each header field
   localparam logic [3:0] WINDOW_BYTES = 4'd8;
   localparam logic [2:0] FIELD_BYTES  = 3'd4;

   // extra payload bytes that follow an eref length
   localparam logic [32:0] EREF_EXTRA = 33'd8;

   typedef enum logic [2:0] {
      PH_HUNT = 3'd0,
      PH_CMD  = 3'd1,
      PH_EXC  = 3'd2,
      PH_LEN  = 3'd3,
      PH_PAY  = 3'd4
   } phase_type;

   typedef enum logic [2:0] {
      ST_HUNT_FILL     = 3'd0,
      ST_HUNT_MISMATCH = 3'd1,
      ST_SYNC_MATCH    = 3'd2,
      ST_HDR_BYTE      = 3'd3,
      ST_HDR_DONE      = 3'd4,
      ST_PAYLOAD       = 3'd5,
      ST_DROPPED       = 3'd6
   } status_type;

   typedef enum logic [3:0] {
      CMD_NONE = 4'd0,
      CMD_CNNT = 4'd1,
      CMD_FOBJ = 4'd2,
      CMD_RSLT = 4'd3,
      CMD_TEXT = 4'd4,
      CMD_EERR = 4'd5,
      CMD_EREF = 4'd6,
      CMD_FSTK = 4'd7,
      CMD_EEXT = 4'd8
   } cmd_type;

   typedef struct packed {
      logic [7:0] rx_byte;
   } req_payload_type;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  data_byte;
      logic [3:0]  command;
      logic [31:0] msg_length;
      logic [31:0] exception_code;
      logic        send_ack;
      logic        end_of_message;
   } rsp_payload_type;

   // map four command characters to their code, none when unknown
   function automatic cmd_type cmd_lookup(input logic [31:0] chars);
      cmd_type code;
      unique case (chars)
         32'h636E6E74: code = CMD_CNNT;
         32'h666F626A: code = CMD_FOBJ;
         32'h72736C74: code = CMD_RSLT;
         32'h74657874: code = CMD_TEXT;
         32'h65657272: code = CMD_EERR;
         32'h65726566: code = CMD_EREF;
         32'h6673746B: code = CMD_FSTK;
         32'h65657874: code = CMD_EEXT;
         default:      code = CMD_NONE;
      endcase
      return code;
   endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/scd_stream_if.sv -----
// scd_stream_if: valid/ready stream channel carrying one item per handshake
// no dependencies; payload type set by the instantiating module
`default_nettype none

interface scd_stream_if #(
   parameter type payload_type = logic
);
   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/scd_parser.sv -----
// scd_parser: deframer state registers and per-byte decode into one result
// depends on scd_pkg
`default_nettype none

module scd_parser (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  logic [7:0]               rx_byte,
   output scd_pkg::rsp_payload_type result
);
   import scd_pkg::*;

   phase_type   phase_ff, phase_in;
   logic [63:0] window_ff, window_in;
   logic [3:0]  fill_ff, fill_in;
   cmd_type     code_ff, code_in;
   logic [31:0] chars_ff, chars_in;
   logic [2:0]  count_ff, count_in;
   logic [31:0] length_ff, length_in;
   logic [31:0] exc_ff, exc_in;
   logic [32:0] remain_ff, remain_in;

   logic [2:0]  count_inc;
   logic [63:0] window_shift;
   logic [3:0]  fill_next;
   cmd_type     code_found;
   logic [31:0] length_shift;
   logic [32:0] remain_dec;
   status_type  status;
   logic        go_hunt;
   logic        ack;
   logic        eom;

   always_comb begin
      phase_in  = phase_ff;
      window_in = window_ff;
      fill_in   = fill_ff;
      code_in   = code_ff;
      chars_in  = chars_ff;
      count_in  = count_ff;
      length_in = length_ff;
      exc_in    = exc_ff;
      remain_in = remain_ff;
      status    = ST_HUNT_FILL;
      go_hunt   = 1'b0;
      ack       = 1'b0;
      eom       = 1'b0;

      count_inc    = count_ff + 3'd1;
      window_shift = {window_ff[55:0], rx_byte};
      fill_next    = (fill_ff < WINDOW_BYTES) ? fill_ff + 4'd1 : fill_ff;
      code_found   = cmd_lookup({chars_ff[23:0], rx_byte});
      length_shift = {length_ff[23:0], rx_byte};
      remain_dec   = remain_ff - {32'd0, (remain_ff != 33'd0)};

      unique case (phase_ff)
         PH_CMD: begin
            chars_in = {chars_ff[23:0], rx_byte};
            count_in = count_inc;
            status   = ST_HDR_BYTE;
            if (count_inc >= FIELD_BYTES) begin
               count_in = 3'd0;
               code_in  = code_found;
               if (code_found == CMD_NONE) begin
                  status  = ST_DROPPED;
                  go_hunt = 1'b1;
               end else begin
                  phase_in = (code_found == CMD_EERR) ? PH_EXC : PH_LEN;
               end
            end
         end
         PH_EXC: begin
            exc_in   = {exc_ff[23:0], rx_byte};
            count_in = count_inc;
            status   = ST_HDR_BYTE;
            if (count_inc >= FIELD_BYTES) begin
               count_in = 3'd0;
               phase_in = PH_LEN;
            end
         end
         PH_LEN: begin
            length_in = length_shift;
            count_in  = count_inc;
            status    = ST_HDR_BYTE;
            if (count_inc >= FIELD_BYTES) begin
               count_in  = 3'd0;
               status    = ST_HDR_DONE;
               remain_in = {1'b0, length_shift} +
                           ((code_ff == CMD_EREF) ? EREF_EXTRA : 33'd0);
               ack       = (code_ff == CMD_CNNT);
               if (remain_in == 33'd0) begin
                  eom     = 1'b1;
                  go_hunt = 1'b1;
               end else begin
                  phase_in = PH_PAY;
               end
            end
         end
         PH_PAY: begin
            status    = ST_PAYLOAD;
            remain_in = remain_dec;
            if (remain_dec == 33'd0) begin
               eom     = 1'b1;
               go_hunt = 1'b1;
            end
         end
         default: begin
            // hunting, also taken by the unused phase codes
            phase_in  = PH_HUNT;
            window_in = window_shift;
            fill_in   = fill_next;
            if (fill_next >= WINDOW_BYTES) begin
               if (window_shift == SYNC_WORD) begin
                  status    = ST_SYNC_MATCH;
                  phase_in  = PH_CMD;
                  count_in  = 3'd0;
                  code_in   = CMD_NONE;
                  chars_in  = 32'd0;
                  length_in = 32'd0;
                  exc_in    = 32'd0;
                  remain_in = 33'd0;
               end else begin
                  status = ST_HUNT_MISMATCH;
               end
            end
         end
      endcase

      result.status         = status;
      result.data_byte      = rx_byte;
      result.command        = code_in;
      result.msg_length     = (status == ST_HDR_DONE || status == ST_PAYLOAD) ?
                              length_in : 32'd0;
      result.exception_code = ((status == ST_HDR_DONE || status == ST_PAYLOAD) &&
                               code_in == CMD_EERR) ? exc_in : 32'd0;
      result.send_ack       = ack;
      result.end_of_message = eom;

      if (go_hunt) begin
         phase_in  = PH_HUNT;
         window_in = 64'd0;
         fill_in   = 4'd0;
         code_in   = CMD_NONE;
         count_in  = 3'd0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HUNT;
         window_ff <= 64'd0;
         fill_ff   <= 4'd0;
         code_ff   <= CMD_NONE;
         count_ff  <= 3'd0;
      end else if (step_en) begin
         phase_ff  <= phase_in;
         window_ff <= window_in;
         fill_ff   <= fill_in;
         code_ff   <= code_in;
         count_ff  <= count_in;
      end
   end

   // fields below are cleared on every sync match before they are read
   always_ff @(posedge clock) begin
      if (step_en) begin
         chars_ff  <= chars_in;
         length_ff <= length_in;
         exc_ff    <= exc_in;
         remain_ff <= remain_in;
      end
   end

endmodule

`default_nettype wire

// ----- hw/rtl/sync_command_deframer.sv -----
// sync_command_deframer: top level with input register, parser and result register
// depends on scd_pkg, scd_stream_if and scd_parser
//
// usage
//   req_chan carries one received byte per item (rx_byte); rsp_chan returns
//   exactly one result item per byte, in order: status, echoed data_byte,
//   command code, msg_length, exception_code, send_ack and end_of_message
//   both channels use valid/ready; an item moves when both are high at a
//   rising clock edge
//   path: a taken byte waits in the input register, is decoded from there and
//   is registered into the result register, which drives rsp_chan
//   throughput: one item per cycle while rsp_chan is ready; the only loop is the
//   parser state update, done combinationally from the input register
//   reset (synchronous, active high) empties both registers and returns the
//   parser to hunting with an empty sync window
//   when the receiver stalls, the result register holds its item and the
//   input register can still take one more byte; only with both full does
//   req_chan.ready drop
`default_nettype none

module sync_command_deframer (
   input  logic         clock,
   input  logic         reset,
   scd_stream_if.sink   req_chan,
   scd_stream_if.source rsp_chan
);
   import scd_pkg::*;

   // input register
   logic            in_valid_ff, in_valid_in;
   logic [7:0]      in_byte_ff;

   // result register
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff;

   rsp_payload_type step_result;
   logic            advance;
   logic            req_take;

   // the input item moves on when the result register is empty or draining
   assign advance  = in_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_take = req_chan.valid && req_chan.ready;

   assign req_chan.ready   = !in_valid_ff || advance;
   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_take) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_byte_ff <= req_chan.payload.rx_byte;
      end
      if (advance) begin
         rsp_data_ff <= step_result;
      end
   end

   // parser state steps exactly once per byte leaving the input register
   scd_parser u_parser (
      .clock   (clock),
      .reset   (reset),
      .step_en (advance),
      .rx_byte (in_byte_ff),
      .result  (step_result)
   );

   // an acknowledge only comes with a completed cnnt header
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.send_ack |->
         rsp_data_ff.status == ST_HDR_DONE && rsp_data_ff.command == CMD_CNNT)
      else $error("send_ack outside a cnnt header end");

   // a message ends only on its header end or on a payload byte
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_data_ff.end_of_message |->
         rsp_data_ff.status == ST_HDR_DONE || rsp_data_ff.status == ST_PAYLOAD)
      else $error("end_of_message on a non-message byte");

   // a decoded byte always shows up in the result register next cycle
   assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff && rsp_data_ff.data_byte == $past(in_byte_ff))
      else $error("decoded item lost on the way to the result register");

   // no new byte is taken while both registers are full and stalled
   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && rsp_valid_ff && !rsp_chan.ready |-> !req_chan.ready)
      else $error("input accepted while pipeline is full");

endmodule

`default_nettype wire
